// ===== rtl/ddp_pkg.sv =====
// ddp_pkg: types and constants shared by the distance difference pixel core
// item structs, register codes and the fixed widths of the datapath
// no dependencies
package ddp_pkg;

  // field and datapath widths, all fixed by the 8-bit pixel and 12-bit points
  localparam int PIX_W   = 8;
  localparam int COORD_W = 12;
  localparam int DX_W    = 13;  // pixel minus point, signed
  localparam int SQ_W    = 23;  // one squared difference
  localparam int D2_W    = 24;  // squared distance
  localparam int ROOT_W  = 20;  // sqrt of squared distance << 16, q.8
  localparam int REM_W   = 22;  // sqrt partial remainder
  localparam int DIFF_W  = 21;  // signed difference of two roots
  localparam int Q_W     = 14;  // difference after scaling

  // times two then drop the 8 fractional bits
  localparam int DIFF_SHIFT = 7;
  localparam int BLUE_MID   = 128;

  // pipeline shape
  localparam int SQ_STAGES     = 3;
  localparam int SQRT_STEPS    = ROOT_W;
  localparam int PRE_DEPTH     = SQ_STAGES + SQRT_STEPS;
  // stages ahead of the output, plus difference stage, output and skid registers
  localparam int MAX_IN_FLIGHT = PRE_DEPTH + 3;

  // register port
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  typedef enum logic [1:0] {
    REG_POINT_A_X = 2'd0,
    REG_POINT_A_Y = 2'd1,
    REG_POINT_B_X = 2'd2,
    REG_POINT_B_Y = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_x;
    logic [PIX_W-1:0] pixel_y;
  } in_item_t;

  typedef struct packed {
    logic [PIX_W-1:0] red_channel;
    logic [PIX_W-1:0] green_channel;
    logic [PIX_W-1:0] blue_channel;
  } out_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] a_x;
    logic signed [COORD_W-1:0] a_y;
    logic signed [COORD_W-1:0] b_x;
    logic signed [COORD_W-1:0] b_y;
  } points_t;

endpackage

// ===== rtl/ddp_regs.sv =====
// ddp_regs: register file for the two reference points
// apb-style write and read port, depends on ddp_pkg
module ddp_regs (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [ddp_pkg::ADDR_W-1:0] paddr,
  input  logic [ddp_pkg::DATA_W-1:0] pwdata,
  output logic [ddp_pkg::DATA_W-1:0] prdata,
  output logic                      pready,
  output ddp_pkg::points_t          points_o
);
  import ddp_pkg::*;

  points_t  points_q;
  logic     wr_en;
  reg_idx_e idx;
  logic signed [COORD_W-1:0] rd_val;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;
  assign idx    = reg_idx_e'(paddr[3:2]);

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      points_q <= '0;
    end else if (wr_en) begin
      case (idx)
        REG_POINT_A_X: points_q.a_x <= pwdata[COORD_W-1:0];
        REG_POINT_A_Y: points_q.a_y <= pwdata[COORD_W-1:0];
        REG_POINT_B_X: points_q.b_x <= pwdata[COORD_W-1:0];
        REG_POINT_B_Y: points_q.b_y <= pwdata[COORD_W-1:0];
        default: ;
      endcase
    end
  end

  // read mux, sign-extended
  always_comb begin
    case (idx)
      REG_POINT_A_X: rd_val = points_q.a_x;
      REG_POINT_A_Y: rd_val = points_q.a_y;
      REG_POINT_B_X: rd_val = points_q.b_x;
      REG_POINT_B_Y: rd_val = points_q.b_y;
      default:       rd_val = '0;
    endcase
  end

  assign prdata   = {{(DATA_W-COORD_W){rd_val[COORD_W-1]}}, rd_val};
  assign points_o = points_q;

endmodule

// ===== rtl/ddp_dist_sq.sv =====
// ddp_dist_sq: three-stage squared distance from a pixel to one point
// difference, square, sum; depends on ddp_pkg
module ddp_dist_sq (
  input  logic                               clk_i,
  input  logic                               en_i,
  input  logic [ddp_pkg::PIX_W-1:0]          pixel_x_i,
  input  logic [ddp_pkg::PIX_W-1:0]          pixel_y_i,
  input  logic signed [ddp_pkg::COORD_W-1:0] ref_x_i,
  input  logic signed [ddp_pkg::COORD_W-1:0] ref_y_i,
  output logic [ddp_pkg::D2_W-1:0]           d2_o
);
  import ddp_pkg::*;

  logic signed [DX_W-1:0]   dx_d, dy_d, dx_q, dy_q;
  logic signed [2*DX_W-1:0] prod_x, prod_y;
  logic [SQ_W-1:0]          sqx_q, sqy_q;
  logic [D2_W-1:0]          d2_d, d2_q;

  // stage 1: coordinate differences
  assign dx_d = $signed({{(DX_W-PIX_W){1'b0}}, pixel_x_i}) - $signed({ref_x_i[COORD_W-1], ref_x_i});
  assign dy_d = $signed({{(DX_W-PIX_W){1'b0}}, pixel_y_i}) - $signed({ref_y_i[COORD_W-1], ref_y_i});

  // stage 2: squares, never negative and below 2^23
  assign prod_x = dx_q * dx_q;
  assign prod_y = dy_q * dy_q;

  // stage 3: sum of squares
  assign d2_d = {1'b0, sqx_q} + {1'b0, sqy_q};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dx_q  <= dx_d;
      dy_q  <= dy_d;
      sqx_q <= prod_x[SQ_W-1:0];
      sqy_q <= prod_y[SQ_W-1:0];
      d2_q  <= d2_d;
    end
  end

  assign d2_o = d2_q;

endmodule

// ===== rtl/ddp_sqrt_step.sv =====
// ddp_sqrt_step: one registered digit step of the restoring square root
// takes two radicand bits and yields one root bit; depends on ddp_pkg
module ddp_sqrt_step (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic [ddp_pkg::D2_W-1:0]   rad_i,
  input  logic [ddp_pkg::REM_W-1:0]  rem_i,
  input  logic [ddp_pkg::ROOT_W-1:0] root_i,
  output logic [ddp_pkg::D2_W-1:0]   rad_o,
  output logic [ddp_pkg::REM_W-1:0]  rem_o,
  output logic [ddp_pkg::ROOT_W-1:0] root_o
);
  import ddp_pkg::*;

  logic [REM_W+1:0]  rem_sh, trial, rem_sub;
  logic              fits;
  logic [D2_W-1:0]   rad_q;
  logic [REM_W-1:0]  rem_q;
  logic [ROOT_W-1:0] root_q;

  // bring down the next pair and try root*4+1
  assign rem_sh  = {rem_i, rad_i[D2_W-1 -: 2]};
  assign trial   = {{(REM_W-ROOT_W){1'b0}}, root_i, 2'b01};
  assign fits    = rem_sh >= trial;
  assign rem_sub = rem_sh - trial;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // consumed bits leave at the top, zeros fill the fractional part
      rad_q  <= {rad_i[D2_W-3:0], 2'b00};
      rem_q  <= fits ? rem_sub[REM_W-1:0] : rem_sh[REM_W-1:0];
      root_q <= {root_i[ROOT_W-2:0], fits};
    end
  end

  assign rad_o  = rad_q;
  assign rem_o  = rem_q;
  assign root_o = root_q;

endmodule

// ===== rtl/ddp_out_stage.sv =====
// ddp_out_stage: distance difference, blue scaling and saturation,
// output register with a one-item skid; depends on ddp_pkg
module ddp_out_stage (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  input  ddp_pkg::in_item_t          tag_i,
  input  logic [ddp_pkg::ROOT_W-1:0] root_a_i,
  input  logic [ddp_pkg::ROOT_W-1:0] root_b_i,
  output logic                       en_o,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output ddp_pkg::out_item_t         out_item_o
);
  import ddp_pkg::*;

  logic                     vld_q;
  in_item_t                 tag_q;
  logic signed [DIFF_W-1:0] diff_d, diff_q, diff_adj;
  logic signed [Q_W-1:0]    q, blue_s;
  logic [PIX_W-1:0]         blue;
  out_item_t                tail_item, out_q, skid_q;
  logic                     out_valid_q, skid_valid_q, out_held;

  // the pipeline moves whenever the skid register is free
  assign en_o     = !skid_valid_q;
  assign out_held = out_valid_q & out_stall_i;

  // difference stage
  assign diff_d = $signed({1'b0, root_a_i}) - $signed({1'b0, root_b_i});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_o) begin
      vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_o) begin
      tag_q  <= tag_i;
      diff_q <= diff_d;
    end
  end

  // scale by two over 256, truncating toward zero, then clamp around mid grey
  assign diff_adj = diff_q + (diff_q[DIFF_W-1] ? DIFF_W'(2**DIFF_SHIFT - 1) : '0);
  assign q        = Q_W'(diff_adj >>> DIFF_SHIFT);
  assign blue_s   = q + Q_W'(BLUE_MID);

  always_comb begin
    if (q < -BLUE_MID) begin
      blue = '0;
    end else if (q > BLUE_MID - 1) begin
      blue = '1;
    end else begin
      blue = blue_s[PIX_W-1:0];
    end
  end

  assign tail_item = '{red_channel: tag_q.pixel_x, green_channel: tag_q.pixel_y,
                       blue_channel: blue};

  // output and skid control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (!out_stall_i) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end
    end else if (out_held) begin
      skid_valid_q <= vld_q;
    end else begin
      out_valid_q <= vld_q;
    end
  end

  // output and skid data
  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (!out_stall_i) begin
        out_q <= skid_q;
      end
    end else if (out_held) begin
      skid_q <= tail_item;
    end else begin
      out_q <= tail_item;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

// ===== rtl/distance_difference_pixel_core.sv =====
// distance_difference_pixel_core: top level of the distance difference pixel core
// depends on ddp_pkg, ddp_regs, ddp_dist_sq, ddp_sqrt_step, ddp_out_stage
//
// Takes one pixel coordinate per item and returns one RGB item: red is the
// column, green the row, and blue is 128 plus twice the difference of the
// distances to points A and B (each a floor square root in q.8), truncated
// toward zero and clamped to 0..255. The core accepts one item every cycle
// while in_stall_o is low, also while earlier items are still in flight:
// three stages form the squared distances, twenty stages run the square roots
// one root bit per stage for both points side by side, and one stage forms the
// difference ahead of the output register. A one-item skid behind the output
// register keeps in_stall_o registered: it rises with the edge that catches a
// valid item behind a stalled output and the whole pipeline holds until the
// skid drains. Point registers sit at byte addresses 0, 4, 8 and 12 (A x, A y,
// B x, B y, 12-bit two's complement); the user must see that they are written
// only while the core holds no item, as nothing in the core enforces it.
module distance_difference_pixel_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  ddp_pkg::in_item_t          in_item_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output ddp_pkg::out_item_t         out_item_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ddp_pkg::ADDR_W-1:0] paddr,
  input  logic [ddp_pkg::DATA_W-1:0] pwdata,
  output logic [ddp_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);
  import ddp_pkg::*;

  points_t           points;
  logic              en, accept;
  logic [PRE_DEPTH-1:0] vld_q;
  in_item_t          tag_q [PRE_DEPTH];
  logic [D2_W-1:0]   d2_a, d2_b;
  logic [D2_W-1:0]   rad_a [SQRT_STEPS+1];
  logic [D2_W-1:0]   rad_b [SQRT_STEPS+1];
  logic [REM_W-1:0]  rem_a [SQRT_STEPS+1];
  logic [REM_W-1:0]  rem_b [SQRT_STEPS+1];
  logic [ROOT_W-1:0] root_a [SQRT_STEPS+1];
  logic [ROOT_W-1:0] root_b [SQRT_STEPS+1];

  assign in_stall_o = !en;
  assign accept     = in_valid_i & en;

  ddp_regs u_regs (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .points_o (points)
  );

  // valid bits and pixel coordinates travel beside the datapath
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[PRE_DEPTH-2:0], accept};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      tag_q[0] <= in_item_i;
      for (int k = 1; k < PRE_DEPTH; k++) begin
        tag_q[k] <= tag_q[k-1];
      end
    end
  end

  // squared distances to both points
  ddp_dist_sq u_dist_a (
    .clk_i     (clk_i),
    .en_i      (en),
    .pixel_x_i (in_item_i.pixel_x),
    .pixel_y_i (in_item_i.pixel_y),
    .ref_x_i   (points.a_x),
    .ref_y_i   (points.a_y),
    .d2_o      (d2_a)
  );

  ddp_dist_sq u_dist_b (
    .clk_i     (clk_i),
    .en_i      (en),
    .pixel_x_i (in_item_i.pixel_x),
    .pixel_y_i (in_item_i.pixel_y),
    .ref_x_i   (points.b_x),
    .ref_y_i   (points.b_y),
    .d2_o      (d2_b)
  );

  // square root pipelines, one root bit per stage
  assign rad_a[0]  = d2_a;
  assign rad_b[0]  = d2_b;
  assign rem_a[0]  = '0;
  assign rem_b[0]  = '0;
  assign root_a[0] = '0;
  assign root_b[0] = '0;

  for (genvar s = 0; s < SQRT_STEPS; s++) begin : g_sqrt
    ddp_sqrt_step u_step_a (
      .clk_i  (clk_i),
      .en_i   (en),
      .rad_i  (rad_a[s]),
      .rem_i  (rem_a[s]),
      .root_i (root_a[s]),
      .rad_o  (rad_a[s+1]),
      .rem_o  (rem_a[s+1]),
      .root_o (root_a[s+1])
    );

    ddp_sqrt_step u_step_b (
      .clk_i  (clk_i),
      .en_i   (en),
      .rad_i  (rad_b[s]),
      .rem_i  (rem_b[s]),
      .root_i (root_b[s]),
      .rad_o  (rad_b[s+1]),
      .rem_o  (rem_b[s+1]),
      .root_o (root_b[s+1])
    );
  end

  // difference, blue and output buffering
  ddp_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (vld_q[PRE_DEPTH-1]),
    .tag_i       (tag_q[PRE_DEPTH-1]),
    .root_a_i    (root_a[SQRT_STEPS]),
    .root_b_i    (root_b[SQRT_STEPS]),
    .en_o        (en),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

// ===== rtl/ddp_checker.sv =====
// ddp_checker: port-level checks for distance_difference_pixel_core
// bound to the top level below; depends on ddp_pkg
module ddp_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  logic                       in_stall_o,
  input  logic                       out_valid_o,
  input  logic                       out_stall_i,
  input  ddp_pkg::out_item_t         out_item_o
);
  import ddp_pkg::*;

  localparam int CNT_W = $clog2(MAX_IN_FLIGHT + 1);

  logic             in_acc, out_acc;
  logic [CNT_W-1:0] cnt_q;

  assign in_acc  = in_valid_i & !in_stall_o;
  assign out_acc = out_valid_o & !out_stall_i;

  // items accepted but not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (in_acc && !out_acc) begin
      cnt_q <= cnt_q + 1'b1;
    end else if (out_acc && !in_acc) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled output item changed");

  // no result without an item behind it
  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> cnt_q != '0)
    else $error("output item with nothing in flight");

  // the pipeline never holds more than its stages
  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(MAX_IN_FLIGHT))
    else $error("too many items in flight");

  // input back-pressure only follows a stalled output
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(out_valid_o && out_stall_i))
    else $error("input stalled without output back-pressure");

endmodule

bind distance_difference_pixel_core ddp_checker u_ddp_checker (.*);

// ===== bench/tb_top.sv =====
// tb_top: self-checking bench for distance_difference_pixel_core
// drives pixel items and point registers, predicts each rgb item and checks it
// depends on ddp_pkg and distance_difference_pixel_core
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ddp_pkg::*;

  localparam logic signed [COORD_W-1:0] C_MIN  = 12'sh800;
  localparam logic signed [COORD_W-1:0] C_MAX  = 12'sh7FF;
  localparam logic signed [COORD_W-1:0] C_ZERO = 12'sh000;
  localparam logic signed [COORD_W-1:0] C_NEG1 = 12'shFFF;
  localparam logic signed [COORD_W-1:0] C_EDGE [4] = '{C_MIN, C_MAX, C_ZERO, C_NEG1};

  localparam int RND_PHASES   = 8;
  localparam int PHASE_PIXELS = 150;
  localparam int FLUSH_CYCLES = 40;
  localparam int MAX_REPORTS  = 10;

  // one directed row: point set, pixel, and a blue value typed in where obvious
  typedef struct packed {
    logic signed [COORD_W-1:0] ax;
    logic signed [COORD_W-1:0] ay;
    logic signed [COORD_W-1:0] bx;
    logic signed [COORD_W-1:0] by;
    logic [PIX_W-1:0]          x;
    logic [PIX_W-1:0]          y;
    logic                      typed;
    logic [PIX_W-1:0]          blue;
  } dir_row_t;

  localparam int NUM_DIR = 21;
  localparam dir_row_t DIR_TAB [NUM_DIR] = '{
    // both points at the origin after reset: blue stays at mid scale
    '{C_ZERO, C_ZERO, C_ZERO, C_ZERO, 8'd0,   8'd0,   1'b1, 8'd128},
    '{C_ZERO, C_ZERO, C_ZERO, C_ZERO, 8'd255, 8'd255, 1'b1, 8'd128},
    '{C_ZERO, C_ZERO, C_ZERO, C_ZERO, 8'd170, 8'd85,  1'b1, 8'd128},
    '{C_ZERO, C_ZERO, C_ZERO, C_ZERO, 8'd85,  8'd170, 1'b1, 8'd128},
    // a far away, b at origin: saturates high
    '{C_MAX,  C_ZERO, C_ZERO, C_ZERO, 8'd0,   8'd0,   1'b1, 8'd255},
    '{C_MAX,  C_ZERO, C_ZERO, C_ZERO, 8'd255, 8'd255, 1'b1, 8'd255},
    // b far away, a at origin: saturates low
    '{C_ZERO, C_ZERO, C_MIN,  C_ZERO, 8'd0,   8'd0,   1'b1, 8'd0},
    '{C_ZERO, C_ZERO, C_MIN,  C_ZERO, 8'd255, 8'd255, 1'b1, 8'd0},
    '{C_ZERO, C_ZERO, C_MIN,  C_ZERO, 8'd255, 8'd0,   1'b1, 8'd0},
    // opposite corners of the coordinate range
    '{C_MIN,  C_MIN,  C_MAX,  C_MAX,  8'd0,   8'd0,   1'b0, 8'd0},
    '{C_MIN,  C_MIN,  C_MAX,  C_MAX,  8'd255, 8'd0,   1'b0, 8'd0},
    '{C_MIN,  C_MIN,  C_MAX,  C_MAX,  8'd0,   8'd255, 1'b0, 8'd0},
    '{C_MAX,  C_MIN,  C_MIN,  C_MAX,  8'd128, 8'd127, 1'b0, 8'd0},
    // equal points away from the origin
    '{C_NEG1, C_NEG1, C_NEG1, C_NEG1, 8'd100, 8'd200, 1'b1, 8'd128},
    // small differences: truncation toward zero on both signs, then wide and equal-distance point sets
    '{C_ZERO, C_ZERO, 12'sd1, C_ZERO, 8'd0,   8'd0,   1'b0, 8'd0},
    '{C_ZERO, C_ZERO, 12'sd1, C_ZERO, 8'd0,   8'd1,   1'b0, 8'd0},
    '{C_ZERO, C_ZERO, 12'sd1, C_ZERO, 8'd1,   8'd1,   1'b0, 8'd0},
    '{C_ZERO, C_ZERO, C_ZERO, 12'sd1, 8'd1,   8'd0,   1'b0, 8'd0},
    '{C_ZERO, C_MIN,  C_ZERO, C_MAX,  8'd255, 8'd255, 1'b0, 8'd0},
    '{12'sd30, 12'sd40, 12'sd40, 12'sd30, 8'd35, 8'd35, 1'b0, 8'd0},
    '{C_MAX,  C_MAX,  C_MIN,  C_MIN,  8'd255, 8'd255, 1'b0, 8'd0}
  };

  logic                clk_i;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  in_item_t            in_item_i   = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  out_item_t           out_item_o;
  logic                psel        = 1'b0;
  logic                penable     = 1'b0;
  logic                pwrite      = 1'b0;
  logic [ADDR_W-1:0]   paddr       = '0;
  logic [DATA_W-1:0]   pwdata      = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  // predictor copy of the point registers and the rgb items still owed
  points_t   cur_pts = '0;
  out_item_t pending_px [$];
  int        bad_cnt = 0;

  // sender burst shaping
  int burst_left = 0;
  int max_gap    = 3;

  // receiver stall pattern
  int stall_mode = 0;
  int mode_left  = 0;
  int run_left   = 0;
  bit run_stall  = 1'b0;

  distance_difference_pixel_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // floor square root of d2 scaled by 2^16, found one result bit at a time
  function automatic logic [ROOT_W-1:0] root_q8(logic [D2_W-1:0] d2);
    logic [D2_W+15:0]  target;
    logic [ROOT_W-1:0] r;
    logic [ROOT_W-1:0] trial;
    logic [D2_W+15:0]  wide;
    target = {d2, 16'h0000};
    r = '0;
    for (int b = ROOT_W - 1; b >= 0; b--) begin
      trial = r | (ROOT_W'(1) << b);
      wide  = (D2_W+16)'(trial);
      if (wide * wide <= target) r = trial;
    end
    return r;
  endfunction

  function automatic logic [ROOT_W-1:0] dist_q8(logic [PIX_W-1:0] px, logic [PIX_W-1:0] py,
                                                logic signed [COORD_W-1:0] rx,
                                                logic signed [COORD_W-1:0] ry);
    int dx;
    int dy;
    dx = int'(px) - int'(rx);
    dy = int'(py) - int'(ry);
    return root_q8(D2_W'(dx * dx + dy * dy));
  endfunction

  // expected rgb item for a pixel under the current point registers
  function automatic out_item_t pixel_colour(in_item_t it);
    out_item_t res;
    int        da;
    int        db;
    int        level;
    da = int'(dist_q8(it.pixel_x, it.pixel_y, cur_pts.a_x, cur_pts.a_y));
    db = int'(dist_q8(it.pixel_x, it.pixel_y, cur_pts.b_x, cur_pts.b_y));
    // signed int division truncates toward zero
    level = BLUE_MID + ((da - db) * 2) / 256;
    if (level < 0) level = 0;
    if (level > 255) level = 255;
    res.red_channel   = it.pixel_x;
    res.green_channel = it.pixel_y;
    res.blue_channel  = PIX_W'(level);
    return res;
  endfunction

  function automatic logic signed [COORD_W-1:0] rand_coord(int kind);
    case (kind)
      0: return C_EDGE[$urandom_range(0, 3)];
      1: return COORD_W'(int'($urandom_range(0, 383)) - 64);
      default: return COORD_W'($urandom_range(0, 4095));
    endcase
  endfunction

  // point sets per random phase: extremes first, then equal points, then a mix
  function automatic points_t pick_points(int ph);
    points_t p;
    case (ph)
      0: p = '{C_MIN, C_MIN, C_MAX, C_MAX};
      1: p = '{C_MAX, C_MIN, C_MIN, C_MAX};
      2: begin
        p.a_x = rand_coord(1);
        p.a_y = rand_coord(1);
        p.b_x = p.a_x;
        p.b_y = p.a_y;
      end
      default: begin
        p.a_x = rand_coord($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 2));
        p.a_y = rand_coord($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 2));
        p.b_x = rand_coord($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 2));
        p.b_y = rand_coord($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 2));
      end
    endcase
    return p;
  endfunction

  function automatic in_item_t rand_pixel();
    in_item_t it;
    it.pixel_x = ($urandom_range(0, 15) == 0) ? ($urandom_range(0, 1) ? 8'hFF : 8'h00)
                                              : PIX_W'($urandom_range(0, 255));
    it.pixel_y = ($urandom_range(0, 15) == 0) ? ($urandom_range(0, 1) ? 8'hFF : 8'h00)
                                              : PIX_W'($urandom_range(0, 255));
    return it;
  endfunction

  function automatic void note_bad(string msg);
    bad_cnt++;
    if (bad_cnt <= MAX_REPORTS) $display("%0t: %s", $realtime, msg);
  endfunction

  // hold the sender off until every owed item has come back
  task automatic drain_pixels();
    in_valid_i <= 1'b0;
    while (pending_px.size() != 0) @(posedge clk_i);
  endtask

  // write all four point registers back to back while the core is empty
  task automatic load_points(points_t p);
    logic [COORD_W-1:0] val;
    drain_pixels();
    for (int i = 0; i < 4; i++) begin
      case (reg_idx_e'(i))
        REG_POINT_A_X: val = p.a_x;
        REG_POINT_A_Y: val = p.a_y;
        REG_POINT_B_X: val = p.b_x;
        REG_POINT_B_Y: val = p.b_y;
        default:       val = '0;
      endcase
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= ADDR_W'(i * 4);
      pwdata  <= DATA_W'($signed(val));
      @(posedge clk_i);
      penable <= 1'b1;
      do @(posedge clk_i); while (!pready);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cur_pts = p;
  endtask

  // present one pixel item, with a random gap at the start of each burst
  task automatic send_pixel(in_item_t it, out_item_t want);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = $urandom_range(0, max_gap);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    pending_px.push_back(want);
    burst_left--;
  endtask

  // result side: check each accepted item, then pick the next stall value
  always @(posedge clk_i) begin : rx_side
    out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_px.size() == 0) begin
        note_bad($sformatf("unexpected pixel r=%0d g=%0d b=%0d", out_item_o.red_channel,
                           out_item_o.green_channel, out_item_o.blue_channel));
      end else begin
        want = pending_px.pop_front();
        if (out_item_o.red_channel !== want.red_channel ||
            out_item_o.green_channel !== want.green_channel ||
            out_item_o.blue_channel !== want.blue_channel) begin
          note_bad($sformatf("pixel mismatch: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                             want.red_channel, want.green_channel, want.blue_channel,
                             out_item_o.red_channel, out_item_o.green_channel,
                             out_item_o.blue_channel));
        end
      end
    end
    // stall pattern: none, scattered, or long runs
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      mode_left  = $urandom_range(50, 300);
    end
    mode_left--;
    case (stall_mode)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(0, 3) == 0);
      default: begin
        if (run_left == 0) begin
          run_stall = !run_stall;
          run_left  = $urandom_range(1, 16);
        end
        run_left--;
        out_stall_i <= run_stall;
      end
    endcase
  end

  // stimulus: directed table, then random phases under changing points
  initial begin : stim
    in_item_t  it;
    out_item_t want;
    points_t   row_pts;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < NUM_DIR; i++) begin
      row_pts = '{DIR_TAB[i].ax, DIR_TAB[i].ay, DIR_TAB[i].bx, DIR_TAB[i].by};
      if (i == 0 || row_pts != cur_pts) load_points(row_pts);
      it.pixel_x = DIR_TAB[i].x;
      it.pixel_y = DIR_TAB[i].y;
      if (DIR_TAB[i].typed) begin
        want = '{DIR_TAB[i].x, DIR_TAB[i].y, DIR_TAB[i].blue};
      end else begin
        want = pixel_colour(it);
      end
      send_pixel(it, want);
    end

    for (int ph = 0; ph < RND_PHASES; ph++) begin
      load_points(pick_points(ph));
      case (ph % 3)
        0: max_gap = 0;
        1: max_gap = 2;
        default: max_gap = 8;
      endcase
      for (int k = 0; k < PHASE_PIXELS; k++) begin
        it = rand_pixel();
        send_pixel(it, pixel_colour(it));
        if ($urandom_range(0, 199) == 0) drain_pixels();
      end
    end

    drain_pixels();
    repeat (FLUSH_CYCLES) @(posedge clk_i);
    if (bad_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
